// File: hdl/rpb_pkg.sv
`default_nettype none
package rpb_pkg;

  // Channel width; all-ones stands for 1.0
  localparam int unsigned ChannelBits = 8;
  localparam int unsigned ModeBits    = 4;
  // Mix weight counts in 1/256 steps, 256 is full source
  localparam int unsigned MixBits     = 9;
  localparam int unsigned MixShift    = 8;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = 9;

  localparam logic [MixBits-1:0] MixFull = MixBits'(1 << MixShift);
  localparam int unsigned MixSumBits  = ChannelBits + MixBits + 1;
  localparam logic [MixSumBits-1:0] MixRound = MixSumBits'(1 << (MixShift - 1));

  // Multiply mode: (d*s + M/2) / M with M = 2^N - 1
  localparam int unsigned ProdBits = 2 * ChannelBits;
  localparam logic [ProdBits-1:0] MulHalf = ProdBits'(((1 << ChannelBits) - 1) >> 1);

  typedef logic [ChannelBits-1:0] chan_t;

  typedef enum logic [ModeBits-1:0] {
    MODE_COPY     = 4'd0,
    MODE_AVG      = 4'd1,
    MODE_ADD_SAT  = 4'd2,
    MODE_CHECKER  = 4'd3,
    MODE_SUB_SRC  = 4'd4,
    MODE_EVEN_ROW = 4'd5,
    MODE_XOR      = 4'd6,
    MODE_MAX      = 4'd7,
    MODE_MIN      = 4'd8,
    MODE_SUB_DST  = 4'd9,
    MODE_MUL      = 4'd10,
    MODE_MIX      = 4'd11
  } blend_mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_BLEND_MODE = 1'd0,
    CFG_MIX_AMOUNT = 1'd1
  } cfg_index_e;

  typedef struct packed {
    chan_t dst_red;
    chan_t dst_green;
    chan_t dst_blue;
    chan_t src_red;
    chan_t src_green;
    chan_t src_blue;
    logic  column_odd;
    logic  row_odd;
  } in_beat_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
  } out_beat_t;

  // Per-beat control shared by all three channels
  typedef struct packed {
    blend_mode_e        mode;
    logic               copy_here;
    logic [MixBits-1:0] mix_w;
  } ctl_t;

endpackage
`default_nettype wire

// File: hdl/rgb_pixel_blend_unit.sv
// The done strobe of a start beat comes out of the valid-bit chain in step with its result.
// Throughput: one pixel per cycle; busy is never raised, the three-stage
//   channel pipeline (products, rounding sums, divide and select) is fully fed.
// The receiver cannot stall; each result stands for one cycle only.
// Reset (rst_ni low, asynchronous) clears the pipeline valid bits and sets
//   blend_mode and mix_amount to 0.
`default_nettype none
module rgb_pixel_blend_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire rpb_pkg::in_beat_t                   in_data_i,
  output logic                                     done_o,
  output rpb_pkg::out_beat_t                       out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [rpb_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  wire logic [rpb_pkg::CfgDataBits-1:0]     cfg_data_i
);

  localparam int unsigned Stages = 3;

  // configuration registers
  logic [rpb_pkg::ModeBits-1:0] mode_q;
  logic [rpb_pkg::MixBits-1:0]  mix_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      mix_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (rpb_pkg::cfg_index_e'(cfg_index_i))
        rpb_pkg::CFG_BLEND_MODE: mode_q <= cfg_data_i[rpb_pkg::ModeBits-1:0];
        rpb_pkg::CFG_MIX_AMOUNT: mix_q  <= cfg_data_i[rpb_pkg::MixBits-1:0];
        default: ;
      endcase
    end
  end

  // per-beat control
  rpb_pkg::ctl_t ctl_w;

  always_comb begin
    ctl_w.mode  = rpb_pkg::blend_mode_e'(mode_q);
    ctl_w.mix_w = (mix_q > rpb_pkg::MixFull) ? rpb_pkg::MixFull : mix_q;
    if (ctl_w.mode == rpb_pkg::MODE_CHECKER) begin
      ctl_w.copy_here = (in_data_i.column_odd == in_data_i.row_odd);
    end else begin
      ctl_w.copy_here = !in_data_i.row_odd;
    end
  end

  // valid bits travel alongside the channel stages
  logic [Stages-1:0] valid_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Stages-2:0], start & !busy};
    end
  end

  assign done_o = valid_q[Stages-1];

  // channel datapaths
  rpb_channel u_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_w),
    .dst_i  (in_data_i.dst_red),
    .src_i  (in_data_i.src_red),
    .res_o  (out_data_o.out_red)
  );

  rpb_channel u_green (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_w),
    .dst_i  (in_data_i.dst_green),
    .src_i  (in_data_i.src_green),
    .res_o  (out_data_o.out_green)
  );

  rpb_channel u_blue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_w),
    .dst_i  (in_data_i.dst_blue),
    .src_i  (in_data_i.src_blue),
    .res_o  (out_data_o.out_blue)
  );

endmodule
`default_nettype wire

// File: hdl/rpb_channel.sv
`default_nettype none
module rpb_channel (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rpb_pkg::ctl_t  ctl_i,
  input  wire rpb_pkg::chan_t dst_i,
  input  wire rpb_pkg::chan_t src_i,
  output rpb_pkg::chan_t     res_o
);

  localparam int unsigned N  = rpb_pkg::ChannelBits;
  localparam int unsigned PW = rpb_pkg::ProdBits;
  localparam int unsigned MW = N + rpb_pkg::MixBits;
  localparam int unsigned SW = rpb_pkg::MixSumBits;

  // stage 1: simple rules and products
  logic [N:0]                  sum_w;
  rpb_pkg::chan_t              simple_d, simple1_q, simple2_q;
  logic [rpb_pkg::MixBits-1:0] wd_w;
  logic [PW-1:0]               prod_d, prod_q;
  logic [MW-1:0]               pdst_d, pdst_q, psrc_d, psrc_q;
  rpb_pkg::blend_mode_e        mode1_q, mode2_q;

  assign sum_w = {1'b0, dst_i} + {1'b0, src_i};
  assign wd_w  = rpb_pkg::MixFull - ctl_i.mix_w;

  always_comb begin
    unique case (ctl_i.mode)
      rpb_pkg::MODE_AVG:     simple_d = sum_w[N:1];
      rpb_pkg::MODE_ADD_SAT: simple_d = sum_w[N] ? '1 : sum_w[N-1:0];
      rpb_pkg::MODE_CHECKER,
      rpb_pkg::MODE_EVEN_ROW: simple_d = ctl_i.copy_here ? src_i : dst_i;
      rpb_pkg::MODE_SUB_SRC: simple_d = (dst_i > src_i) ? dst_i - src_i : '0;
      rpb_pkg::MODE_XOR:     simple_d = dst_i ^ src_i;
      rpb_pkg::MODE_MAX:     simple_d = (dst_i > src_i) ? dst_i : src_i;
      rpb_pkg::MODE_MIN:     simple_d = (dst_i < src_i) ? dst_i : src_i;
      rpb_pkg::MODE_SUB_DST: simple_d = (src_i > dst_i) ? src_i - dst_i : '0;
      default:               simple_d = src_i;
    endcase
  end

  assign prod_d = PW'(dst_i) * PW'(src_i);
  assign pdst_d = MW'(dst_i) * MW'(wd_w);
  assign psrc_d = MW'(src_i) * MW'(ctl_i.mix_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode1_q <= rpb_pkg::MODE_COPY;
      mode2_q <= rpb_pkg::MODE_COPY;
    end else begin
      mode1_q <= ctl_i.mode;
      mode2_q <= mode1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    simple1_q <= simple_d;
    prod_q    <= prod_d;
    pdst_q    <= pdst_d;
    psrc_q    <= psrc_d;
  end

  // stage 2: rounding sums
  logic [PW-1:0] mul_d, mul_q;
  logic [SW-1:0] mix_d, mix_q;

  assign mul_d = prod_q + rpb_pkg::MulHalf;
  assign mix_d = SW'(pdst_q) + SW'(psrc_q) + rpb_pkg::MixRound;

  always_ff @(posedge clk_i) begin
    simple2_q <= simple1_q;
    mul_q     <= mul_d;
    mix_q     <= mix_d;
  end

  // stage 3: divide by all-ones, select result
  logic [PW:0]    quo_w;
  rpb_pkg::chan_t res_d, res_q;

  // x / (2^N - 1) = (x + (x >> N) + 1) >> N for x below (2^N - 1)^2 + 2^N
  assign quo_w = {1'b0, mul_q} + (PW+1)'(mul_q[PW-1:N]) + (PW+1)'(1);

  always_comb begin
    unique case (mode2_q)
      rpb_pkg::MODE_MUL: res_d = quo_w[2*N-1:N];
      rpb_pkg::MODE_MIX: res_d = mix_q[N+rpb_pkg::MixShift-1:rpb_pkg::MixShift];
      default:           res_d = simple2_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire
